>>> rtl/pidt_pkg.sv
// shared constants and types for the trapezoid pid controller
`default_nettype none

package pidt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PROD_SH   = 2 * FRAC_BITS;

    localparam int ERR_W   = 32;
    localparam int DT_W    = 16;
    localparam int GAIN_W  = 32;
    localparam int LIM_W   = 16;
    localparam int INTEG_W = 48;
    localparam int SUM_W   = ERR_W + 1;
    localparam int AREA_W  = SUM_W + DT_W;
    localparam int ACC_W   = INTEG_W + GAIN_W + 4;
    localparam int CNT_W   = $clog2(GAIN_W + 1);
    localparam int CFG_W   = 3;

    localparam logic [CFG_W-1:0] CFG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_W-1:0] CFG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_W-1:0] CFG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_W-1:0] CFG_OUT_MAX    = 3'd3;
    localparam logic [CFG_W-1:0] CFG_OUT_MIN    = 3'd4;

    localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = 32'd327680;
    localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = 32'd109227;
    localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = 32'd65536;
    localparam logic [LIM_W-1:0]  RST_OUT_MAX    = 16'd255;
    localparam logic [LIM_W-1:0]  RST_OUT_MIN    = 16'd0;

    typedef struct packed {
        logic start;
        logic clear;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/pidt_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module pidt_div
    import pidt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ERR_W-1:0]  i_dividend,
    input  wire logic [DT_W-1:0]   i_divisor,
    output logic                   o_busy,
    output logic [ERR_W-1:0]       o_quot
);

    logic [ERR_W-1:0] r_quot;
    logic [DT_W-1:0]  r_rem;
    logic [DT_W-1:0]  r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DT_W:0] trial;
    logic [DT_W:0] diff;
    logic          fits;

    assign trial = {r_rem, r_quot[ERR_W-1]};
    assign diff  = trial - {1'b0, r_div};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ERR_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            // dividend bits leave at the top, quotient bits enter at the bottom
            r_quot <= {r_quot[ERR_W-2:0], fits};
            r_rem  <= fits ? diff[DT_W-1:0] : trial[DT_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> rtl/pidt_mac.sv
// serial shift-add multiply-accumulate, one gain bit per cycle
`default_nettype none

module pidt_mac
    import pidt_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_mac_ctl                   i_ctl,
    input  wire logic [GAIN_W-1:0]          i_gain,
    input  wire logic signed [INTEG_W-1:0]  i_x,
    output logic                            o_busy,
    output logic signed [ACC_W-1:0]         o_acc
);

    logic signed [ACC_W-1:0] r_x;
    logic signed [ACC_W-1:0] r_acc;
    logic [GAIN_W-1:0]       r_g;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(GAIN_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= ACC_W'(i_x);
            r_g <= i_gain;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (r_busy) begin
            if (r_g[0]) begin
                r_acc <= r_acc + r_x;
            end
            r_x <= r_x <<< 1;
            r_g <= r_g >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

>>> rtl/pid_trapezoid_clamped.sv
// pid controller step: trapezoid integral, derivative by division, clamped drive
//
// Input channel: i_in_valid / o_in_stall carry one word per control step, a
// signed Q16.16 error and the elapsed milliseconds. Output channel:
// o_out_valid / i_out_stall carry one drive word per input word.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 gain_prop, 1 gain_integ, 2 gain_deriv, 3 out_max, 4 out_min); other
// indexes are ignored. Write only while no step is in flight.
// One word at a time: the block accepts a word, then works through three
// passes of a shared bit-serial multiply-accumulate unit before the drive
// lands in the output register (the divider and the trapezoid multiplier
// run under the first pass). The next word is accepted the cycle after the
// drive is loaded, even while that drive still waits to be taken. Reset
// restores the register defaults and clears the integral and the previous
// error. When the receiver stalls, the output word holds; a finished step
// waits until the output register is free.
`default_nettype none

module pid_trapezoid_clamped
    import pidt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ERR_W-1:0]  i_error_in,
    input  wire logic [DT_W-1:0]   i_delta_ms,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [LIM_W-1:0]       o_drive_out,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_W-1:0]  i_cfg_index,
    input  wire logic [GAIN_W-1:0] i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RUN1    = 8'b0000_0010,
        S_INTEG   = 8'b0000_0100,
        S_START_I = 8'b0000_1000,
        S_WAIT_I  = 8'b0001_0000,
        S_START_D = 8'b0010_0000,
        S_WAIT_D  = 8'b0100_0000,
        S_CLAMP   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [GAIN_W-1:0] r_gain_prop;
    logic [GAIN_W-1:0] r_gain_integ;
    logic [GAIN_W-1:0] r_gain_deriv;
    logic [LIM_W-1:0]  r_out_max;
    logic [LIM_W-1:0]  r_out_min;

    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_prev;
    logic [DT_W-1:0]           r_dt;
    logic                      r_dneg;

    logic signed [AREA_W-1:0] r_area_x;
    logic signed [AREA_W-1:0] r_area_acc;
    logic [DT_W-1:0]          r_area_m;
    logic [CNT_W-1:0]         r_area_cnt;

    logic             r_out_valid;
    logic [LIM_W-1:0] r_drive;

    logic in_acc;
    logic out_free;

    logic signed [SUM_W-1:0] sum_e;
    logic signed [SUM_W-1:0] diff_e;
    logic signed [SUM_W-1:0] diff_mag;

    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] n_integ;

    logic signed [SUM_W-1:0]   quot_s;
    logic signed [INTEG_W-1:0] deriv;

    t_mac_ctl                  mac_ctl;
    logic [GAIN_W-1:0]         mac_gain;
    logic signed [INTEG_W-1:0] mac_x;
    logic                      mac_busy;
    logic signed [ACC_W-1:0]   mac_acc;

    logic             div_busy;
    logic [ERR_W-1:0] div_quot;

    logic signed [ACC_W-1:0] hi_bound;
    logic signed [ACC_W-1:0] lo_bound;
    logic                    above_hi;
    logic                    below_lo;
    logic [LIM_W-1:0]        drive;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop  <= RST_GAIN_PROP;
            r_gain_integ <= RST_GAIN_INTEG;
            r_gain_deriv <= RST_GAIN_DERIV;
            r_out_max    <= RST_OUT_MAX;
            r_out_min    <= RST_OUT_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN_PROP:  r_gain_prop  <= i_cfg_data;
                CFG_GAIN_INTEG: r_gain_integ <= i_cfg_data;
                CFG_GAIN_DERIV: r_gain_deriv <= i_cfg_data;
                CFG_OUT_MAX:    r_out_max    <= i_cfg_data[LIM_W-1:0];
                CFG_OUT_MIN:    r_out_min    <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- step front end ----------------
    assign sum_e    = SUM_W'($signed(i_error_in)) + SUM_W'(r_prev);
    assign diff_e   = SUM_W'($signed(i_error_in)) - SUM_W'(r_prev);
    assign diff_mag = diff_e[SUM_W-1] ? -diff_e : diff_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (in_acc) begin
            r_prev <= $signed(i_error_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dt   <= i_delta_ms;
            r_dneg <= diff_e[SUM_W-1];
        end
    end

    // trapezoid area: (error + previous) * dt, one dt bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_cnt <= '0;
        end else if (in_acc) begin
            r_area_cnt <= CNT_W'(DT_W);
        end else if (r_area_cnt != '0) begin
            r_area_cnt <= r_area_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_area_x   <= AREA_W'(sum_e);
            r_area_m   <= i_delta_ms;
            r_area_acc <= '0;
        end else if (r_area_cnt != '0) begin
            if (r_area_m[0]) begin
                r_area_acc <= r_area_acc + r_area_x;
            end
            r_area_x <= r_area_x <<< 1;
            r_area_m <= r_area_m >> 1;
        end
    end

    // integral update with floor halving and saturation
    assign integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r_area_acc >>> 1);

    always_comb begin
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integ = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (r_state == S_INTEG) begin
            r_integ <= n_integ;
        end
    end

    // ---------------- derivative divider ----------------
    pidt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc),
        .i_dividend (diff_mag[ERR_W-1:0]),
        .i_divisor  (i_delta_ms),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign quot_s = r_dneg ? -SUM_W'($signed({1'b0, div_quot}))
                           : SUM_W'($signed({1'b0, div_quot}));
    assign deriv  = (r_dt == '0) ? '0 : INTEG_W'(quot_s);

    // ---------------- shared multiply-accumulate ----------------
    always_comb begin
        mac_ctl.start = in_acc || (r_state == S_START_I) || (r_state == S_START_D);
        mac_ctl.clear = in_acc;
        if (r_state == S_START_I) begin
            mac_gain = r_gain_integ;
            mac_x    = r_integ;
        end else if (r_state == S_START_D) begin
            mac_gain = r_gain_deriv;
            mac_x    = deriv;
        end else begin
            mac_gain = r_gain_prop;
            mac_x    = INTEG_W'($signed(i_error_in));
        end
    end

    pidt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_gain  (mac_gain),
        .i_x     (mac_x),
        .o_busy  (mac_busy),
        .o_acc   (mac_acc)
    );

    // ---------------- clamp ----------------
    assign hi_bound = $signed({{(ACC_W-LIM_W-PROD_SH){1'b0}}, r_out_max, {PROD_SH{1'b0}}});
    assign lo_bound = $signed({{(ACC_W-LIM_W-PROD_SH){1'b0}}, r_out_min, {PROD_SH{1'b0}}});
    assign above_hi = mac_acc > hi_bound;
    assign below_lo = mac_acc < lo_bound;

    always_comb begin
        if (above_hi) begin
            drive = r_out_max;
        end else if (below_lo) begin
            drive = r_out_min;
        end else begin
            drive = mac_acc[PROD_SH+LIM_W-1:PROD_SH];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_RUN1;
            S_RUN1:    if (!mac_busy && !div_busy && r_area_cnt == '0) n_state = S_INTEG;
            S_INTEG:   n_state = S_START_I;
            S_START_I: n_state = S_WAIT_I;
            S_WAIT_I:  if (!mac_busy) n_state = S_START_D;
            S_START_D: n_state = S_WAIT_D;
            S_WAIT_D:  if (!mac_busy) n_state = S_CLAMP;
            S_CLAMP:   if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_CLAMP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLAMP && out_free) begin
            r_drive <= drive;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_drive_out = r_drive;

    // ---------------- checks ----------------
    a_mac_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> mac_busy && div_busy)
        else $error("multiply or divide unit did not start on an accepted word");

    a_mac_idle_on_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START_I || r_state == S_START_D) |-> !mac_busy)
        else $error("multiply unit restarted while busy");

    a_acc_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLAMP && !out_free) |=> $stable(mac_acc))
        else $error("accumulator changed while drive waits");

    a_out_from_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_CLAMP))
        else $error("drive word appeared outside the clamp step");

endmodule

`default_nettype wire
